FILE: rtl/core/mfbr_pkg.sv
// mfbr_pkg: shared types and constants for the MSB-first bit reader.
// Holds the transaction codes, status codes, word queue sizing and the front/back structs.
// No dependencies.
package mfbr_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [QCNT_W-1:0] QUEUE_FULL_CNT = QCNT_W'(QUEUE_DEPTH);
   localparam logic [QPTR_W-1:0] QUEUE_LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

   // command queue is a fixed two-entry ring with one-bit pointers
   localparam logic [1:0] CMDQ_FULL_CNT = 2'd2;

   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_SHOW  = 2'd1;
   localparam logic [1:0] KIND_GET   = 2'd2;
   localparam logic [1:0] KIND_FLUSH = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_STARVED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [1:0] PRIMED_NONE = 2'd0;
   localparam logic [1:0] PRIMED_HIGH = 2'd1;
   localparam logic [1:0] PRIMED_BOTH = 2'd2;

   localparam logic [5:0] WORD_BITS = 6'd32;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_SHOW,
      OP_GET,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] word;
      logic [4:0]  nbits;
   } cmd_type;

   typedef struct packed {
      logic [5:0]        bits_left;
      logic [1:0]        primed;
      logic [QCNT_W-1:0] q_count;
   } back_state_type;

endpackage

FILE: rtl/core/mfbr_channels.sv
// mfbr_channels: valid/ready channel interfaces for request and response transactions.
// Depends on nothing; payload widths are fixed by the field definitions.
interface mfbr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] stream_word;
   logic [4:0]  num_bits;

   modport source (output valid, output kind, output stream_word, output num_bits,
                   input ready);
   modport sink   (input valid, input kind, input stream_word, input num_bits,
                   output ready);
endinterface

interface mfbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic [1:0]  status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: rtl/core/mfbr_front.sv
// mfbr_front: accepts request transactions, decodes the kind into an op code and
// buffers decoded commands in a two-entry queue. Depends on mfbr_pkg, mfbr_req_if.
module mfbr_front
   import mfbr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mfbr_req_if.sink      req_chan,
   output logic          cmd_valid,
   input  logic          cmd_ready,
   output cmd_type       cmd
);

   cmd_type     entry_ff [2];
   logic [0:0]  wr_ptr_ff, wr_ptr_in;
   logic [0:0]  rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     cmd_in;
   logic        push, pop;

   assign req_chan.ready = (count_ff != CMDQ_FULL_CNT);
   assign cmd_valid      = (count_ff != 2'd0);
   assign cmd            = entry_ff[rd_ptr_ff];

   assign push = req_chan.valid && req_chan.ready;
   assign pop  = cmd_valid && cmd_ready;

   always_comb begin
      cmd_in.word  = req_chan.stream_word;
      cmd_in.nbits = req_chan.num_bits;
      case (req_chan.kind)
         KIND_PUSH:  cmd_in.op = OP_PUSH;
         KIND_SHOW:  cmd_in.op = OP_SHOW;
         KIND_GET:   cmd_in.op = OP_GET;
         KIND_FLUSH: cmd_in.op = OP_FLUSH;
         default:    cmd_in.op = OP_PUSH;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

FILE: rtl/core/mfbr_back.sv
// mfbr_back: executes decoded commands against the 64-bit window, the word queue and
// the bit count, and holds the response register. Depends on mfbr_pkg, mfbr_rsp_if.
module mfbr_back
   import mfbr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           cmd_valid,
   output logic           cmd_ready,
   input  cmd_type        cmd,
   mfbr_rsp_if.source     rsp_chan,
   output back_state_type state
);

   logic [31:0]       win_hi_ff, win_hi_in;
   logic [31:0]       win_lo_ff, win_lo_in;
   logic [5:0]        bits_left_ff, bits_left_in;
   logic [1:0]        primed_ff, primed_in;
   logic [31:0]       word_q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] q_rd_ptr_ff, q_rd_ptr_in;
   logic [QPTR_W-1:0] q_wr_ptr_ff, q_wr_ptr_in;
   logic [QCNT_W-1:0] q_count_ff, q_count_in;
   logic              q_wr_en;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       value_ff, value_in;
   logic [1:0]        status_ff, status_in;

   logic [63:0]       win;
   logic [6:0]        shamt;
   logic [31:0]       shifted;
   logic [31:0]       mask;
   logic [31:0]       field;
   logic              need_refill;
   logic              fire;

   assign cmd_ready       = !rsp_valid_ff || rsp_chan.ready;
   assign fire            = cmd_valid && cmd_ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.value  = value_ff;
   assign rsp_chan.status = status_ff;

   assign state.bits_left = bits_left_ff;
   assign state.primed    = primed_ff;
   assign state.q_count   = q_count_ff;

   assign win         = {win_hi_ff, win_lo_ff};
   assign shamt       = 7'd32 + {1'b0, bits_left_ff} - {2'b00, cmd.nbits};
   assign shifted     = 32'(win >> shamt);
   assign mask        = 32'((33'd1 << cmd.nbits) - 33'd1);
   assign field       = shifted & mask;
   assign need_refill = ({1'b0, cmd.nbits} > bits_left_ff);

   always_comb begin
      win_hi_in    = win_hi_ff;
      win_lo_in    = win_lo_ff;
      bits_left_in = bits_left_ff;
      primed_in    = primed_ff;
      q_rd_ptr_in  = q_rd_ptr_ff;
      q_wr_ptr_in  = q_wr_ptr_ff;
      q_count_in   = q_count_ff;
      q_wr_en      = 1'b0;
      value_in     = value_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;

      if (fire) begin
         rsp_valid_in = 1'b1;
         value_in     = '0;
         status_in    = ST_OK;
         if (cmd.op == OP_PUSH) begin
            if (primed_ff == PRIMED_NONE) begin
               win_hi_in = cmd.word;
               primed_in = PRIMED_HIGH;
            end else if (primed_ff == PRIMED_HIGH) begin
               win_lo_in    = cmd.word;
               primed_in    = PRIMED_BOTH;
               bits_left_in = WORD_BITS;
            end else if (q_count_ff == QUEUE_FULL_CNT) begin
               status_in = ST_FULL;
            end else begin
               q_wr_en     = 1'b1;
               q_wr_ptr_in = (q_wr_ptr_ff == QUEUE_LAST_PTR) ? '0
                                                             : q_wr_ptr_ff + QPTR_W'(1);
               q_count_in  = q_count_ff + QCNT_W'(1);
            end
         end else if (primed_ff != PRIMED_BOTH) begin
            status_in = ST_STARVED;
         end else if (cmd.op == OP_SHOW) begin
            value_in = field;
         end else if (!need_refill) begin
            bits_left_in = bits_left_ff - 6'(cmd.nbits);
            if (cmd.op == OP_GET) begin
               value_in = field;
            end
         end else if (q_count_ff == '0) begin
            status_in = ST_STARVED;
         end else begin
            win_hi_in    = win_lo_ff;
            win_lo_in    = word_q_ff[q_rd_ptr_ff];
            q_rd_ptr_in  = (q_rd_ptr_ff == QUEUE_LAST_PTR) ? '0
                                                           : q_rd_ptr_ff + QPTR_W'(1);
            q_count_in   = q_count_ff - QCNT_W'(1);
            bits_left_in = bits_left_ff + WORD_BITS - 6'(cmd.nbits);
            if (cmd.op == OP_GET) begin
               value_in = field;
            end
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_hi_ff    <= '0;
         win_lo_ff    <= '0;
         bits_left_ff <= '0;
         primed_ff    <= PRIMED_NONE;
         q_rd_ptr_ff  <= '0;
         q_wr_ptr_ff  <= '0;
         q_count_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_hi_ff    <= win_hi_in;
         win_lo_ff    <= win_lo_in;
         bits_left_ff <= bits_left_in;
         primed_ff    <= primed_in;
         q_rd_ptr_ff  <= q_rd_ptr_in;
         q_wr_ptr_ff  <= q_wr_ptr_in;
         q_count_ff   <= q_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
      if (q_wr_en) begin
         word_q_ff[q_wr_ptr_ff] <= cmd.word;
      end
   end

endmodule

FILE: rtl/core/msb_first_bit_reader.sv
// msb_first_bit_reader: top level of the MSB-first bit field reader.
// Instantiates mfbr_front and mfbr_back; uses mfbr_pkg and mfbr_channels.
//
//   Channel    Modport  Fields                              Role
//   req_chan   sink     kind, stream_word, num_bits         push/show/get/flush transaction
//   rsp_chan   source   value, status                       one response per transaction
//
// Sustained rate is one transaction per cycle while rsp_chan.ready holds; an accepted request
// passes the command queue entry, then the response register, before its response is valid.
// The rate is set by the execute stage, which updates window, bit count and queue together.
// Reset is synchronous: window unprimed, word queue and command queue empty.
// A stalled response holds the execute stage; req_chan.ready drops once both command
// queue entries are occupied.
module msb_first_bit_reader
   import mfbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mfbr_req_if.sink    req_chan,
   mfbr_rsp_if.source  rsp_chan
);

   logic           cmd_valid;
   logic           cmd_ready;
   cmd_type        cmd;
   back_state_type bstate;

   mfbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   mfbr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_chan  (rsp_chan),
      .state     (bstate)
   );

   a_bits_left_range: assert property (@(posedge clock) disable iff (reset)
      bstate.bits_left <= WORD_BITS)
      else $error("bits_left above one word");

   a_queue_count_range: assert property (@(posedge clock) disable iff (reset)
      bstate.q_count <= QUEUE_FULL_CNT)
      else $error("word queue count above depth");

   a_queue_needs_prime: assert property (@(posedge clock) disable iff (reset)
      (bstate.q_count != '0) |-> (bstate.primed == PRIMED_BOTH))
      else $error("word queued before window primed");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_STARVED || rsp_chan.status == ST_FULL))
         |-> (rsp_chan.value == '0))
      else $error("nonzero value with error status");

   a_full_only_primed: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_FULL) |-> (bstate.q_count == QUEUE_FULL_CNT))
      else $error("full status with free queue entry");

endmodule
